// ----- hdl/mcbp_pkg.sv -----
package mcbp_pkg;

	// Result kinds carried on the kind port.
	typedef enum logic [1:0] {
		KIND_SPEED  = 2'd0,
		KIND_DIR    = 2'd1,
		KIND_TARGET = 2'd2
	} kind_t;

	// Action codes found in bits 4:3 of a command byte.
	typedef enum logic [1:0] {
		ACT_SPEED  = 2'd0,
		ACT_DIR    = 2'd1,
		ACT_IGNORE = 2'd2,
		ACT_TARGET = 2'd3
	} action_t;

	// Acknowledge characters returned to the host.
	localparam logic [7:0] ACK_SPEED  = 8'h73;  // 's'
	localparam logic [7:0] ACK_DIR    = 8'h64;  // 'd'
	localparam logic [7:0] ACK_TARGET = 8'h65;  // 'e'

	// Command byte layout.
	localparam int unsigned CMD_MOTOR_BIT = 2;
	localparam int unsigned CMD_ACT_LSB   = 3;
	localparam int unsigned CMD_DIR_BIT   = 5;

	localparam int unsigned MOTORS     = 2;
	localparam int unsigned TARGET_W   = 32;

endpackage

// ----- hdl/motor_command_byte_parser.sv -----
// Parses a stream of received command bytes for two motors. A byte that
// arrives while the parser is idle is a command: bit 2 picks the motor and
// bits 4:3 the action (speed set, direction set, encoder target set, or
// ignored). A speed command takes the next byte as the speed; a target
// command takes the next TARGET_BYTES bytes, most significant first, as a
// signed 32-bit target. Each finished action produces one result word with
// the motor, its current direction and speed, the target and an acknowledge
// character. Every byte is registered on entry and handled, once the result
// register can take a word, by one pass of logic into the result register,
// so the parser takes one byte per clock unless the receiver stalls; a word
// passes through the input register and then the result register. The input
// is stalled only while the result register holds a word the receiver stalls.
module motor_command_byte_parser
	import mcbp_pkg::*;
#(
	parameter int unsigned TARGET_BYTES = 4
) (
	input  logic               clk,
	input  logic               arst_n,
	// Byte input channel.
	input  logic               in_valid,
	output logic               in_stall,
	input  logic [7:0]         rx_byte,
	// Result channel.
	output logic               out_valid,
	input  logic               out_stall,
	output logic [1:0]         kind,
	output logic               motor_index,
	output logic               direction,
	output logic [7:0]         speed,
	output logic signed [31:0] encoder_target,
	output logic [7:0]         ack_char
);

	localparam int unsigned CNT_W = (TARGET_BYTES > 1) ? $clog2(TARGET_BYTES) : 1;

	typedef enum logic [1:0] {
		PH_IDLE   = 2'd0,
		PH_SPEED  = 2'd1,
		PH_TARGET = 2'd2
	} phase_t;

	// Input register.
	logic       valid_s1;
	logic [7:0] byte_s1;

	// Parser state.
	phase_t                phase_q;
	logic                  sel_motor_q;
	logic [CNT_W-1:0]      count_q;
	logic [TARGET_W-1:0]   accum_q;
	logic [MOTORS-1:0]     dir_q;
	logic [7:0]            speed_q [MOTORS];

	// Result register.
	logic                  out_valid_q;
	kind_t                 kind_q;
	logic                  motor_q;
	logic                  dir_out_q;
	logic [7:0]            speed_out_q;
	logic [TARGET_W-1:0]   target_q;
	logic [7:0]            ack_q;

	// Next-state values.
	phase_t                phase_d;
	logic                  sel_motor_d;
	logic [CNT_W-1:0]      count_d;
	logic [TARGET_W-1:0]   accum_d;
	logic [MOTORS-1:0]     dir_d;
	logic [7:0]            speed_d [MOTORS];
	logic                  emit;
	kind_t                 kind_d;
	logic                  motor_d;
	logic [TARGET_W-1:0]   target_d;
	logic [7:0]            ack_d;

	logic                  out_free;
	logic                  advance;
	logic [CNT_W:0]        count_inc;
	logic [TARGET_W-1:0]   accum_shift;
	action_t               action;

	// The held byte moves on once the result register can take a word.
	assign out_free = !out_valid_q || !out_stall;
	assign advance  = valid_s1 && out_free;
	assign in_stall = valid_s1 && !out_free;

	// Input register loads whenever the input side is not stalled.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!in_stall) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (!in_stall) begin
			byte_s1 <= rx_byte;
		end
	end

	assign count_inc   = {1'b0, count_q} + {{CNT_W{1'b0}}, 1'b1};
	assign accum_shift = {accum_q[TARGET_W-9:0], byte_s1};
	assign action      = action_t'(byte_s1[CMD_ACT_LSB +: 2]);

	// One pass over the held byte: state update and result word.
	always_comb begin
		phase_d     = phase_q;
		sel_motor_d = sel_motor_q;
		count_d     = count_q;
		accum_d     = accum_q;
		dir_d       = dir_q;
		speed_d     = speed_q;
		emit        = 1'b0;
		kind_d      = KIND_SPEED;
		motor_d     = sel_motor_q;
		target_d    = '0;
		ack_d       = ACK_SPEED;
		case (phase_q)
			PH_SPEED: begin
				speed_d[sel_motor_q] = byte_s1;
				phase_d              = PH_IDLE;
				emit                 = 1'b1;
			end
			PH_TARGET: begin
				if (count_inc >= TARGET_BYTES[CNT_W:0]) begin
					accum_d  = '0;
					count_d  = '0;
					phase_d  = PH_IDLE;
					emit     = 1'b1;
					kind_d   = KIND_TARGET;
					target_d = accum_shift;
					ack_d    = ACK_TARGET;
				end else begin
					accum_d = accum_shift;
					count_d = count_inc[CNT_W-1:0];
				end
			end
			default: begin
				// Idle, and the unused phase code: the byte is a command.
				phase_d     = PH_IDLE;
				sel_motor_d = byte_s1[CMD_MOTOR_BIT];
				motor_d     = byte_s1[CMD_MOTOR_BIT];
				case (action)
					ACT_SPEED: begin
						phase_d = PH_SPEED;
					end
					ACT_DIR: begin
						dir_d[byte_s1[CMD_MOTOR_BIT]] = byte_s1[CMD_DIR_BIT];
						emit   = 1'b1;
						kind_d = KIND_DIR;
						ack_d  = ACK_DIR;
					end
					ACT_TARGET: begin
						phase_d = PH_TARGET;
						count_d = '0;
						accum_d = '0;
					end
					default: begin
					end
				endcase
			end
		endcase
	end

	// Parser state and result register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q     <= PH_IDLE;
			sel_motor_q <= 1'b0;
			count_q     <= '0;
			accum_q     <= '0;
			dir_q       <= '0;
			speed_q     <= '{default: '0};
			out_valid_q <= 1'b0;
			kind_q      <= KIND_SPEED;
			motor_q     <= 1'b0;
			dir_out_q   <= 1'b0;
			speed_out_q <= '0;
			target_q    <= '0;
			ack_q       <= '0;
		end else begin
			if (out_free) begin
				out_valid_q <= advance && emit;
			end
			if (advance) begin
				phase_q     <= phase_d;
				sel_motor_q <= sel_motor_d;
				count_q     <= count_d;
				accum_q     <= accum_d;
				dir_q       <= dir_d;
				speed_q     <= speed_d;
				if (emit) begin
					kind_q      <= kind_d;
					motor_q     <= motor_d;
					dir_out_q   <= dir_d[motor_d];
					speed_out_q <= speed_d[motor_d];
					target_q    <= target_d;
					ack_q       <= ack_d;
				end
			end
		end
	end

	assign out_valid      = out_valid_q;
	assign kind           = kind_q;
	assign motor_index    = motor_q;
	assign direction      = dir_out_q;
	assign speed          = speed_out_q;
	assign encoder_target = signed'(target_q);
	assign ack_char       = ack_q;

endmodule

// ----- tb/sv/tb_motor_command_byte_parser.sv -----
module tb_motor_command_byte_parser
	import mcbp_pkg::*;
();

	localparam int unsigned TARGET_BYTES = 4;
	localparam int unsigned RANDOM_BYTES = 1650;
	localparam int unsigned STALL_LIMIT  = 2000;

	// One expected or observed result word.
	typedef struct packed {
		kind_t              kind;
		logic               motor;
		logic               dir;
		logic [7:0]         spd;
		logic signed [31:0] target;
		logic [7:0]         ack;
	} result_word_t;

	// One row of the directed table: the byte and, where obvious, its result.
	typedef struct packed {
		logic [7:0]   rx;
		logic         typed;
		result_word_t word;
	} stim_row_t;

	typedef enum logic [1:0] {
		PH_IDLE   = 2'd0,
		PH_SPEED  = 2'd1,
		PH_TARGET = 2'd2
	} parse_phase_t;

	localparam result_word_t NO_WORD = '{KIND_SPEED, 1'b0, 1'b0, 8'h00, 32'sd0, 8'h00};

	logic               clk;
	logic               arst_n = 1'b0;
	logic               in_valid = 1'b0;
	logic               in_stall;
	logic [7:0]         rx_byte = 8'h00;
	logic               out_valid;
	logic               out_stall = 1'b0;
	logic [1:0]         kind;
	logic               motor_index;
	logic               direction;
	logic [7:0]         speed;
	logic signed [31:0] encoder_target;
	logic [7:0]         ack_char;

	// Shadow copy of the parser state.
	parse_phase_t       shadow_phase;
	logic               shadow_motor;
	int unsigned        shadow_count;
	logic [31:0]        shadow_acc;
	logic               shadow_dir [MOTORS];
	logic [7:0]         shadow_speed [MOTORS];
	logic [31:0]        shadow_goal [MOTORS];

	result_word_t       expected_words [$];
	int unsigned        errors;
	int unsigned        bytes_sent;
	int unsigned        useful_bytes;
	int unsigned        words_checked;
	int unsigned        kind_seen [3];
	int unsigned        quiet_cycles;
	bit                 calm;

	// Directed table: extremes of every field, every action, unused command bits.
	stim_row_t directed_rows [0:25] = '{
		'{8'h08, 1'b1, '{KIND_DIR, 1'b0, 1'b0, 8'h00, 32'sd0, ACK_DIR}},
		'{8'h2C, 1'b1, '{KIND_DIR, 1'b1, 1'b1, 8'h00, 32'sd0, ACK_DIR}},
		'{8'h00, 1'b0, NO_WORD},
		'{8'hFF, 1'b1, '{KIND_SPEED, 1'b0, 1'b0, 8'hFF, 32'sd0, ACK_SPEED}},
		'{8'hC7, 1'b0, NO_WORD},
		'{8'h00, 1'b1, '{KIND_SPEED, 1'b1, 1'b1, 8'h00, 32'sd0, ACK_SPEED}},
		'{8'hD3, 1'b0, NO_WORD},
		'{8'hF6, 1'b0, NO_WORD},
		'{8'hFB, 1'b0, NO_WORD},
		'{8'h80, 1'b0, NO_WORD},
		'{8'h00, 1'b0, NO_WORD},
		'{8'h00, 1'b0, NO_WORD},
		'{8'h00, 1'b1, '{KIND_TARGET, 1'b0, 1'b0, 8'hFF, 32'sh8000_0000, ACK_TARGET}},
		'{8'h1C, 1'b0, NO_WORD},
		'{8'h7F, 1'b0, NO_WORD},
		'{8'hFF, 1'b0, NO_WORD},
		'{8'hFF, 1'b0, NO_WORD},
		'{8'hFF, 1'b1, '{KIND_TARGET, 1'b1, 1'b1, 8'h00, 32'sh7FFF_FFFF, ACK_TARGET}},
		'{8'h20, 1'b0, NO_WORD},
		'{8'h08, 1'b0, NO_WORD},
		'{8'hE8, 1'b0, NO_WORD},
		'{8'h1C, 1'b0, NO_WORD},
		'{8'hFF, 1'b0, NO_WORD},
		'{8'hFF, 1'b0, NO_WORD},
		'{8'hFF, 1'b0, NO_WORD},
		'{8'hFF, 1'b0, NO_WORD}
	};

	motor_command_byte_parser #(
		.TARGET_BYTES(TARGET_BYTES)
	) u_dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.in_valid      (in_valid),
		.in_stall      (in_stall),
		.rx_byte       (rx_byte),
		.out_valid     (out_valid),
		.out_stall     (out_stall),
		.kind          (kind),
		.motor_index   (motor_index),
		.direction     (direction),
		.speed         (speed),
		.encoder_target(encoder_target),
		.ack_char      (ack_char)
	);

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	// Apply one byte to the shadow state and say which word, if any, it yields.
	function automatic bit parse_byte(input logic [7:0] b, output result_word_t word,
			output bit ignored);
		logic    m;
		action_t act;
		word    = NO_WORD;
		ignored = 1'b0;
		case (shadow_phase)
			PH_SPEED: begin
				m = shadow_motor;
				shadow_speed[m] = b;
				shadow_phase = PH_IDLE;
				word = '{KIND_SPEED, m, shadow_dir[m], shadow_speed[m], 32'sd0, ACK_SPEED};
				return 1'b1;
			end
			PH_TARGET: begin
				m = shadow_motor;
				shadow_acc = {shadow_acc[23:0], b};
				shadow_count++;
				if (shadow_count >= TARGET_BYTES) begin
					shadow_goal[m] = shadow_acc;
					word = '{KIND_TARGET, m, shadow_dir[m], shadow_speed[m], shadow_acc,
						ACK_TARGET};
					shadow_acc = '0;
					shadow_count = 0;
					shadow_phase = PH_IDLE;
					return 1'b1;
				end
				return 1'b0;
			end
			default: begin
				// Idle: the byte is a command.
				shadow_phase = PH_IDLE;
				m = b[CMD_MOTOR_BIT];
				shadow_motor = m;
				act = action_t'(b[CMD_ACT_LSB +: 2]);
				case (act)
					ACT_SPEED: shadow_phase = PH_SPEED;
					ACT_DIR: begin
						shadow_dir[m] = b[CMD_DIR_BIT];
						word = '{KIND_DIR, m, shadow_dir[m], shadow_speed[m], 32'sd0, ACK_DIR};
						return 1'b1;
					end
					ACT_TARGET: begin
						shadow_phase = PH_TARGET;
						shadow_count = 0;
						shadow_acc = '0;
					end
					default: ignored = 1'b1;
				endcase
				return 1'b0;
			end
		endcase
	endfunction

	task automatic report_mismatch(input string what, input logic [31:0] got,
			input logic [31:0] want);
		errors++;
		$display("mismatch on word %0d, %s: got 0x%0h, expected 0x%0h",
			words_checked, what, got, want);
	endtask

	// Offer one byte, wait for it to be taken, then record what it should yield.
	task automatic send_byte(input logic [7:0] b, input bit typed, input result_word_t typed_word);
		result_word_t word;
		bit           produced;
		bit           ignored;
		while (!calm && $urandom_range(99) < 18) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		rx_byte  <= b;
		@(posedge clk);
		while (in_stall) @(posedge clk);
		bytes_sent++;
		produced = parse_byte(b, word, ignored);
		if (!ignored) useful_bytes++;
		if (typed) expected_words.push_back(typed_word);
		else if (produced) expected_words.push_back(word);
	endtask

	// Hold the input off until every outstanding word has come out.
	task automatic drain_words();
		in_valid <= 1'b0;
		@(posedge clk);
		while (expected_words.size() != 0) @(posedge clk);
	endtask

	// A well-formed command with random content, or now and then a stray byte.
	task automatic send_sequence();
		logic [7:0] cmd;
		logic [7:0] data;
		int unsigned pick;
		pick = $urandom_range(99);
		cmd  = 8'($urandom_range(255));
		if (pick < 15) begin
			send_byte(cmd, 1'b0, NO_WORD);
		end else if (pick < 42) begin
			cmd[CMD_ACT_LSB +: 2] = ACT_SPEED;
			send_byte(cmd, 1'b0, NO_WORD);
			data = 8'($urandom_range(255));
			send_byte(data, 1'b0, NO_WORD);
		end else if (pick < 64) begin
			cmd[CMD_ACT_LSB +: 2] = ACT_DIR;
			send_byte(cmd, 1'b0, NO_WORD);
		end else if (pick < 90) begin
			cmd[CMD_ACT_LSB +: 2] = ACT_TARGET;
			send_byte(cmd, 1'b0, NO_WORD);
			for (int i = 0; i < TARGET_BYTES; i++) begin
				// Occasionally push the target to a sign boundary.
				case ($urandom_range(9))
					0: data = 8'h00;
					1: data = 8'hFF;
					2: data = (i == 0) ? 8'h80 : 8'h00;
					default: data = 8'($urandom_range(255));
				endcase
				send_byte(data, 1'b0, NO_WORD);
			end
		end else begin
			cmd[CMD_ACT_LSB +: 2] = ACT_IGNORE;
			send_byte(cmd, 1'b0, NO_WORD);
		end
	endtask

	// Receiver stall, random except in the calm stretch.
	always @(posedge clk) begin
		out_stall <= !calm && ($urandom_range(99) < 18);
	end

	// Compare each delivered word with the oldest expectation.
	always @(posedge clk) begin
		result_word_t want;
		if (arst_n && out_valid && !out_stall) begin
			words_checked++;
			if (kind < 3) kind_seen[kind]++;
			if (expected_words.size() == 0) begin
				report_mismatch("word with none expected, ack", 32'(ack_char), 32'h0);
			end else begin
				want = expected_words.pop_front();
				if (kind !== want.kind) report_mismatch("kind", 32'(kind), 32'(want.kind));
				if (motor_index !== want.motor)
					report_mismatch("motor_index", 32'(motor_index), 32'(want.motor));
				if (direction !== want.dir)
					report_mismatch("direction", 32'(direction), 32'(want.dir));
				if (speed !== want.spd) report_mismatch("speed", 32'(speed), 32'(want.spd));
				if (encoder_target !== want.target)
					report_mismatch("encoder_target", encoder_target, want.target);
				if (ack_char !== want.ack)
					report_mismatch("ack_char", 32'(ack_char), 32'(want.ack));
			end
		end
	end

	// Watchdog: end the run if no word moves on either side for too long.
	always @(posedge clk) begin
		if (arst_n) begin
			if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
				quiet_cycles = 0;
			end else begin
				quiet_cycles++;
				if (quiet_cycles >= STALL_LIMIT) begin
					$display("watchdog: no handshake for %0d cycles, %0d words outstanding",
						quiet_cycles, expected_words.size());
					$display("tb: failure");
					$finish;
				end
			end
		end
	end

	// Main sequence: reset, directed table, random traffic, drain.
	initial begin
		bit paused;
		errors        = 0;
		bytes_sent    = 0;
		useful_bytes  = 0;
		words_checked = 0;
		quiet_cycles  = 0;
		calm          = 1'b0;
		paused        = 1'b0;
		kind_seen     = '{0, 0, 0};
		shadow_phase  = PH_IDLE;
		shadow_motor  = 1'b0;
		shadow_count  = 0;
		shadow_acc    = '0;
		for (int i = 0; i < MOTORS; i++) begin
			shadow_dir[i]   = 1'b0;
			shadow_speed[i] = 8'h00;
			shadow_goal[i]  = '0;
		end

		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (directed_rows[i])
			send_byte(directed_rows[i].rx, directed_rows[i].typed, directed_rows[i].word);
		drain_words();

		useful_bytes = 0;
		while (useful_bytes < RANDOM_BYTES) begin
			calm = (useful_bytes >= 700 && useful_bytes < 1000);
			if (!paused && useful_bytes >= 1200) begin
				drain_words();
				paused = 1'b1;
			end
			send_sequence();
		end
		calm = 1'b0;

		in_valid <= 1'b0;
		while (expected_words.size() != 0) @(posedge clk);
		repeat (10) @(posedge clk);

		$display("summary: %0d bytes in, %0d words checked (%0d speed, %0d direction, %0d target)",
			bytes_sent, words_checked, kind_seen[0], kind_seen[1], kind_seen[2]);
		$display("summary: both sides stalled at random, with one calm stretch and one full drain");
		if (errors == 0) begin
			$display("tb: success");
		end else begin
			$display("tb: failure");
		end
		$finish;
	end

endmodule

// ----- motor_command_byte_parser.f -----
hdl/mcbp_pkg.sv
hdl/motor_command_byte_parser.sv
tb/sv/tb_motor_command_byte_parser.sv
